### sv/tgarle_pkg.sv
// ============================================================================
// tgarle_pkg: shared types and constants of the TGA run-length decoder
// Field widths, register indexes, header byte masks and the structs that
// pass between the sequencer and the span step unit.
// ============================================================================
package tgarle_pkg;

    // Field widths
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned DIM_W     = 16;
    localparam int unsigned PIX_W     = 32;
    localparam int unsigned CNT_W     = 8;
    localparam int unsigned CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RLE_MODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_IN     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd3;

    // Register reset values and limits
    localparam logic [DIM_W-1:0] RST_WIDTH  = 16'd256;
    localparam logic [DIM_W-1:0] RST_HEIGHT = 16'd256;
    localparam logic [DIM_W-1:0] MIN_WIDTH  = 16'd4;

    // Packet header byte fields and the fixed alpha of 24-bit pixels
    localparam logic [BYTE_W-1:0] HDR_PACKED = 8'h80;
    localparam logic [BYTE_W-1:0] HDR_LEN    = 8'h7f;
    localparam logic [BYTE_W-1:0] FULL_ALPHA = 8'hff;

    // Operands of one span step
    typedef struct packed {
        logic [CNT_W-1:0] remain;
        logic [DIM_W-1:0] column_left;
        logic [PIX_W-1:0] pixels_left;
        logic [DIM_W-1:0] eff_width;
    } t_step_in;

    // Results of one span step
    typedef struct packed {
        logic [CNT_W-1:0] take;
        logic [DIM_W-1:0] column;
        logic [CNT_W-1:0] remain;
        logic [DIM_W-1:0] column_left;
        logic             row_end;
        logic [PIX_W-1:0] pixels_left;
        logic             last;
        logic             done;
    } t_step_out;

endpackage

### sv/tgarle_if.sv
// ============================================================================
// tgarle_if: handshake channels of the TGA run-length decoder
// Byte input, span output and configuration write channels, each with valid,
// ready and its payload.
// ============================================================================

// Encoded byte channel
interface tgarle_in_if;
    logic                           valid;
    logic                           ready;
    logic [tgarle_pkg::BYTE_W-1:0]  data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

// Pixel span channel
interface tgarle_out_if;
    logic                           valid;
    logic                           ready;
    logic [tgarle_pkg::BYTE_W-1:0]  blue;
    logic [tgarle_pkg::BYTE_W-1:0]  green;
    logic [tgarle_pkg::BYTE_W-1:0]  red;
    logic [tgarle_pkg::BYTE_W-1:0]  alpha;
    logic [tgarle_pkg::DIM_W-1:0]   column;
    logic [tgarle_pkg::DIM_W-1:0]   row;
    logic [tgarle_pkg::CNT_W-1:0]   span_count;
    logic                           last_of_item;
    logic                           image_done;

    modport source (output valid, output blue, output green, output red, output alpha,
                    output column, output row, output span_count,
                    output last_of_item, output image_done, input ready);
    modport sink   (input valid, input blue, input green, input red, input alpha,
                    input column, input row, input span_count,
                    input last_of_item, input image_done, output ready);
endinterface

// Configuration write channel
interface tgarle_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [tgarle_pkg::CFG_IDX_W-1:0] reg_index;
    logic [tgarle_pkg::DIM_W-1:0]     wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

### sv/tgarle_span_step.sv
// ============================================================================
// tgarle_span_step: one step of the span splitter
// Takes as many pixels as fit in the current row, works out the span's first
// column and the counts that remain for the next step.
// ============================================================================
module tgarle_span_step (
    input  tgarle_pkg::t_step_in  i_step,
    output tgarle_pkg::t_step_out o_step
);

    logic [tgarle_pkg::CNT_W-1:0] take;
    logic [tgarle_pkg::DIM_W-1:0] col_after;
    logic [tgarle_pkg::PIX_W-1:0] pix_after;
    logic [tgarle_pkg::CNT_W-1:0] rem_after;

    // The span is limited by what is left of the row; a row of fewer
    // pixels than the run always fits in the count field.
    always_comb begin
        if (i_step.column_left < {8'd0, i_step.remain}) begin
            take = i_step.column_left[tgarle_pkg::CNT_W-1:0];
        end else begin
            take = i_step.remain;
        end
        col_after = i_step.column_left - {8'd0, take};
        pix_after = i_step.pixels_left - {24'd0, take};
        rem_after = i_step.remain - take;
    end

    // Wrap to the next row down when this one is full
    always_comb begin
        o_step.take        = take;
        o_step.column      = i_step.eff_width - i_step.column_left;
        o_step.remain      = rem_after;
        o_step.row_end     = (col_after == '0);
        o_step.column_left = (col_after == '0) ? i_step.eff_width : col_after;
        o_step.pixels_left = pix_after;
        o_step.done        = (pix_after == '0);
        o_step.last        = (rem_after == '0) || (pix_after == '0);
    end

endmodule

### sv/tga_truecolor_rle_decoder.sv
// ============================================================================
// tga_truecolor_rle_decoder: truecolor TGA pixel stream decoder
// Assembles pixels from the byte stream, expands run-length packets and
// splits the runs into pixel spans that never cross a row end.
// ============================================================================
// A byte that gives no span (header, blue, green, red of a 32-bit pixel) is
// taken without a stall. A byte that completes a pixel is taken and then
// holds the input off until its spans are out, since a single span step
// unit splits the run at row ends one span a cycle when the output is not
// stalled: one span for a lone pixel, one per row that a packed run touches.
// Back-pressure on the span output lengthens the emission by the stall cycles.
// A configuration write restarts the image; the counters reload in the
// restart state, in which no byte is taken. Rows are filled from image_height-1
// down to 0; bytes arriving after the last pixel of the image are dropped.
module tga_truecolor_rle_decoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    tgarle_in_if.sink           i_in,
    tgarle_out_if.source        o_out,
    tgarle_cfg_if.sink          i_cfg
);

    // Sequencer states
    localparam logic [1:0] S_RESTART = 2'd0;
    localparam logic [1:0] S_IDLE    = 2'd1;
    localparam logic [1:0] S_EMIT    = 2'd2;

    // Pixel byte phases
    localparam logic [1:0] PH_BLUE  = 2'd0;
    localparam logic [1:0] PH_GREEN = 2'd1;
    localparam logic [1:0] PH_RED   = 2'd2;
    localparam logic [1:0] PH_ALPHA = 2'd3;

    logic [1:0]                     r_state;
    logic [1:0]                     n_state;

    // Configuration registers
    logic                           r_rle_mode;
    logic                           r_alpha_in;
    logic [tgarle_pkg::DIM_W-1:0]   r_width;
    logic [tgarle_pkg::DIM_W-1:0]   r_height;

    // Decoder state
    logic [1:0]                     r_phase;
    logic [tgarle_pkg::CNT_W-1:0]   r_packet_left;
    logic                           r_packed;
    logic [23:0]                    r_color;
    logic [tgarle_pkg::BYTE_W-1:0]  r_alpha;
    logic [tgarle_pkg::CNT_W-1:0]   r_remain;
    logic [tgarle_pkg::DIM_W-1:0]   r_eff_w;
    logic [tgarle_pkg::DIM_W-1:0]   r_column_left;
    logic [tgarle_pkg::DIM_W-1:0]   r_row;
    logic [tgarle_pkg::PIX_W-1:0]   r_pixels_left;
    logic                           r_done;

    // Output register
    logic                           r_ovalid;
    logic [tgarle_pkg::BYTE_W-1:0]  r_o_blue;
    logic [tgarle_pkg::BYTE_W-1:0]  r_o_green;
    logic [tgarle_pkg::BYTE_W-1:0]  r_o_red;
    logic [tgarle_pkg::BYTE_W-1:0]  r_o_alpha;
    logic [tgarle_pkg::DIM_W-1:0]   r_o_column;
    logic [tgarle_pkg::DIM_W-1:0]   r_o_row;
    logic [tgarle_pkg::CNT_W-1:0]   r_o_count;
    logic                           r_o_last;
    logic                           r_o_done;

    logic [tgarle_pkg::DIM_W-1:0]   eff_w;
    logic [tgarle_pkg::DIM_W-1:0]   eff_h;
    logic [tgarle_pkg::PIX_W-1:0]   total_pixels;
    logic                           in_fire;
    logic                           cfg_fire;
    logic                           byte_live;
    logic                           is_header;
    logic                           pix_done;
    logic                           out_load;
    logic [tgarle_pkg::CNT_W-1:0]   hdr_len;
    logic [tgarle_pkg::CNT_W-1:0]   hdr_len_clamped;
    logic [tgarle_pkg::BYTE_W-1:0]  b;
    tgarle_pkg::t_step_in           step_in;
    tgarle_pkg::t_step_out          step_out;

    // Handshakes
    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_fire     = i_in.valid && i_in.ready;
    assign cfg_fire    = i_cfg.valid && i_cfg.ready;
    assign out_load    = (r_state == S_EMIT) && (!r_ovalid || o_out.ready);

    // Effective image size and pixel total from the size registers
    assign eff_w        = (r_width < tgarle_pkg::MIN_WIDTH) ? tgarle_pkg::MIN_WIDTH : r_width;
    assign eff_h        = (r_height == '0) ? 16'd1 : r_height;
    assign total_pixels = {16'd0, eff_w} * {16'd0, eff_h};

    // Byte classification
    assign b         = i_in.data_byte;
    assign byte_live = in_fire && !r_done;
    assign is_header = r_rle_mode && (r_packet_left == '0);
    assign pix_done  = byte_live && !is_header
                     && ((r_phase == PH_ALPHA) || ((r_phase == PH_RED) && !r_alpha_in));

    // Packet length, clamped to the pixels still missing
    assign hdr_len = (b & tgarle_pkg::HDR_LEN) + 8'd1;
    always_comb begin
        if (r_pixels_left < {24'd0, hdr_len}) begin
            hdr_len_clamped = r_pixels_left[tgarle_pkg::CNT_W-1:0];
        end else begin
            hdr_len_clamped = hdr_len;
        end
    end

    // Shared span step unit
    assign step_in.remain      = r_remain;
    assign step_in.column_left = r_column_left;
    assign step_in.pixels_left = r_pixels_left;
    assign step_in.eff_width   = r_eff_w;

    tgarle_span_step u_step (
        .i_step (step_in),
        .o_step (step_out)
    );

    // Sequencer
    always_comb begin
        n_state = r_state;
        if (cfg_fire) begin
            n_state = S_RESTART;
        end else begin
            unique case (r_state)
                S_RESTART: n_state = S_IDLE;
                S_IDLE:    if (pix_done) n_state = S_EMIT;
                S_EMIT:    if (out_load && step_out.last) n_state = S_IDLE;
                default:   n_state = S_RESTART;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RESTART;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rle_mode <= 1'b1;
            r_alpha_in <= 1'b1;
            r_width    <= tgarle_pkg::RST_WIDTH;
            r_height   <= tgarle_pkg::RST_HEIGHT;
        end else if (cfg_fire) begin
            unique case (i_cfg.reg_index)
                tgarle_pkg::REG_RLE_MODE:     r_rle_mode <= i_cfg.wr_data[0];
                tgarle_pkg::REG_ALPHA_IN:     r_alpha_in <= i_cfg.wr_data[0];
                tgarle_pkg::REG_IMAGE_WIDTH:  r_width    <= i_cfg.wr_data;
                tgarle_pkg::REG_IMAGE_HEIGHT: r_height   <= i_cfg.wr_data;
                default:                      r_rle_mode <= r_rle_mode;
            endcase
        end
    end

    // Packet and pixel assembly, image counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_BLUE;
            r_packet_left <= '0;
            r_packed      <= 1'b0;
            r_done        <= 1'b0;
        end else if (r_state == S_RESTART) begin
            r_phase       <= PH_BLUE;
            r_packet_left <= '0;
            r_packed      <= 1'b0;
            r_done        <= 1'b0;
            r_color       <= '0;
            r_eff_w       <= eff_w;
            r_column_left <= eff_w;
            r_row         <= eff_h - 16'd1;
            r_pixels_left <= total_pixels;
        end else if (byte_live && is_header) begin
            r_packet_left <= hdr_len_clamped;
            r_packed      <= ((b & tgarle_pkg::HDR_PACKED) != '0);
            r_phase       <= PH_BLUE;
        end else if (byte_live) begin
            unique case (r_phase)
                PH_BLUE: begin
                    r_color[7:0] <= b;
                    r_phase      <= PH_GREEN;
                end
                PH_GREEN: begin
                    r_color[15:8] <= b;
                    r_phase       <= PH_RED;
                end
                PH_RED: begin
                    r_color[23:16] <= b;
                    r_phase        <= r_alpha_in ? PH_ALPHA : PH_BLUE;
                    r_alpha        <= tgarle_pkg::FULL_ALPHA;
                end
                PH_ALPHA: begin
                    r_phase <= PH_BLUE;
                    r_alpha <= b;
                end
                default: r_phase <= PH_BLUE;
            endcase
            // A finished pixel starts a run: the whole packet when packed
            if (pix_done) begin
                if (r_rle_mode && r_packed) begin
                    r_remain      <= r_packet_left;
                    r_packet_left <= '0;
                end else begin
                    r_remain <= 8'd1;
                    if (r_rle_mode) begin
                        r_packet_left <= r_packet_left - 8'd1;
                    end
                end
            end
        end else if (out_load) begin
            r_remain      <= step_out.remain;
            r_column_left <= step_out.column_left;
            r_pixels_left <= step_out.pixels_left;
            if (step_out.row_end) begin
                r_row <= r_row - 16'd1;
            end
            if (step_out.last) begin
                r_done <= step_out.done;
            end
        end
    end

    // Output register: holds a span until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_blue   <= r_color[7:0];
            r_o_green  <= r_color[15:8];
            r_o_red    <= r_color[23:16];
            r_o_alpha  <= r_alpha;
            r_o_column <= step_out.column;
            r_o_row    <= r_row;
            r_o_count  <= step_out.take;
            r_o_last   <= step_out.last;
            r_o_done   <= step_out.done;
        end
    end

    assign o_out.valid        = r_ovalid;
    assign o_out.blue         = r_o_blue;
    assign o_out.green        = r_o_green;
    assign o_out.red          = r_o_red;
    assign o_out.alpha        = r_o_alpha;
    assign o_out.column       = r_o_column;
    assign o_out.row          = r_o_row;
    assign o_out.span_count   = r_o_count;
    assign o_out.last_of_item = r_o_last;
    assign o_out.image_done   = r_o_done;

endmodule

### sv/tgarle_checker.sv
// ============================================================================
// tgarle_checker: port-level checks of the TGA run-length decoder
// Watches the byte and span channels and flags spans that break the
// decoder's own rules.
// ============================================================================
module tgarle_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_ready,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [tgarle_pkg::CNT_W-1:0]   i_out_count,
    input logic                           i_out_last,
    input logic                           i_out_done
);

    // A waiting span stays offered until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("span withdrawn before it was taken");

    // No new byte is taken while spans of the current pixel are still due
    a_busy_while_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_last |-> !i_in_ready)
        else $error("byte taken while a run is still being split");

    // A span covers between one and 128 pixels
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_count != '0) && (i_out_count <= 8'd128))
        else $error("span count out of range");

    // The span that finishes the image also ends its byte's spans
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_done |-> i_out_last)
        else $error("image finished on a span that is not the last of its byte");

endmodule

bind tga_truecolor_rle_decoder tgarle_checker u_tgarle_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_count (o_out.span_count),
    .i_out_last  (o_out.last_of_item),
    .i_out_done  (o_out.image_done)
);
